>>> rtl/core/dldg_pkg.sv
// Shared types, constants and the CRC-16 step for the dynamic label group parser.
// No dependencies; every other file in this block but dldg_ram imports it.
package dldg_pkg;

   localparam int BYTE_W    = 8;
   localparam int SEG_DEPTH = 16;
   localparam int SEG_AW    = $clog2(SEG_DEPTH);
   localparam int NUM_BANKS = 2;
   localparam int BANK_W    = $clog2(NUM_BANKS);
   localparam int RAM_DEPTH = NUM_BANKS * SEG_DEPTH;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // result kinds
   localparam logic [1:0] KIND_LABEL    = 2'd0;
   localparam logic [1:0] KIND_CLEAR    = 2'd1;
   localparam logic [1:0] KIND_CRC_FAIL = 2'd2;

   // first header byte
   localparam int HDR_TOGGLE_BIT = 7;
   localparam int HDR_FIRST_BIT  = 6;
   localparam int HDR_LAST_BIT   = 5;
   localparam int HDR_CMD_BIT    = 4;
   localparam logic [3:0] CMD_CLEAR = 4'b0000;

   // group length is two header bytes plus two CRC bytes, plus data for a label
   localparam logic [4:0] GROUP_OVERHEAD = 5'd4;
   localparam logic [4:0] HDR_LEN        = 5'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       group_start;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] segment_number;
      logic [3:0] charset;
      logic       first_segment;
      logic       last_segment;
      logic       new_label;
      logic [3:0] byte_offset;
      logic [7:0] label_byte;
      logic       last_of_run;
   } rsp_type;

   // one finished group, handed from the front to the back
   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        segment_number;
      logic [3:0]        charset;
      logic              first_segment;
      logic              last_segment;
      logic              new_label;
      logic [SEG_AW-1:0] count_m1;
      logic [BANK_W-1:0] bank;
   } job_type;

   typedef struct packed {
      logic              valid;
      logic [BANK_W-1:0] bank;
   } bank_free_type;

   // CCITT CRC-16, MSB first, one byte
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

>>> rtl/core/dldg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module dldg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/dldg_front.sv
// Front end: takes X-PAD bytes, parses header, runs the CRC, writes label data
// into the segment RAM and queues a job per finished label, clear or CRC-failed group. Uses dldg_pkg.
module dldg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dldg_pkg::req_type             req_data,
   output logic                          push_valid,
   output dldg_pkg::job_type             push_job,
   input  logic                          q_full,
   input  dldg_pkg::bank_free_type       bank_free,
   output logic                          wr_en,
   output logic [dldg_pkg::RAM_AW-1:0]   wr_addr,
   output logic [7:0]                    wr_data
);
   import dldg_pkg::*;

   localparam logic [1:0] PH_WAIT   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [4:0]           br_ff, br_in;
   logic [4:0]           breq_ff, breq_in;
   logic [7:0]           hdr0_ff, hdr0_in;
   logic [7:0]           hdr1_ff, hdr1_in;
   logic [15:0]          trailer_ff, trailer_in;
   logic [15:0]          crc_ff, crc_in;
   logic                 toggle_ff, toggle_in;
   logic                 pending_ff, pending_in;
   logic [BANK_W-1:0]    wbank_ff, wbank_in;
   logic [NUM_BANKS-1:0] busy_ff, busy_in;

   logic        accept;
   logic        start;
   logic [7:0]  b;
   logic [1:0]  ph_eff;
   logic [4:0]  br_eff;
   logic [4:0]  br_inc;
   logic [4:0]  data_idx;
   logic [15:0] crc_eff;
   logic [15:0] crc_fed;
   logic [15:0] trailer_new;
   logic        crc_ok;

   assign req_stall = q_full || busy_ff[wbank_ff];
   assign accept    = req_valid && !req_stall;
   assign start     = req_data.group_start;
   assign b         = req_data.data_byte;

   // a start byte restarts the group before it is parsed as the first header byte
   assign ph_eff      = start ? PH_HEADER : phase_ff;
   assign br_eff      = start ? 5'd0 : br_ff;
   assign crc_eff     = start ? CRC_INIT : crc_ff;
   assign br_inc      = br_eff + 5'd1;
   assign data_idx    = br_ff - HDR_LEN;
   assign crc_fed     = crc_feed(crc_eff, b);
   assign trailer_new = {trailer_ff[7:0], b};
   assign crc_ok      = (~crc_ff) == trailer_new;

   assign wr_addr = {wbank_ff, data_idx[SEG_AW-1:0]};
   assign wr_data = b;

   always_comb begin
      phase_in   = phase_ff;
      br_in      = br_ff;
      breq_in    = breq_ff;
      hdr0_in    = hdr0_ff;
      hdr1_in    = hdr1_ff;
      trailer_in = trailer_ff;
      crc_in     = crc_ff;
      toggle_in  = toggle_ff;
      pending_in = pending_ff;
      wbank_in   = wbank_ff;
      busy_in    = busy_ff;
      wr_en      = 1'b0;
      push_valid = 1'b0;
      push_job   = '0;

      if (bank_free.valid) begin
         busy_in[bank_free.bank] = 1'b0;
      end

      if (accept) begin
         if (start) begin
            phase_in   = PH_HEADER;
            br_in      = 5'd0;
            breq_in    = GROUP_OVERHEAD;
            trailer_in = '0;
            crc_in     = CRC_INIT;
         end
         unique case (ph_eff)
            PH_HEADER: begin
               if (br_eff[0] == 1'b0) begin
                  hdr0_in = b;
               end else begin
                  hdr1_in = b;
               end
               crc_in = crc_fed;
               br_in  = br_inc;
               if (br_inc >= HDR_LEN) begin
                  phase_in = PH_DATA;
                  if (hdr0_ff[HDR_CMD_BIT]) begin
                     breq_in = GROUP_OVERHEAD;
                  end else begin
                     breq_in = GROUP_OVERHEAD + 5'd1 + {1'b0, hdr0_ff[3:0]};
                     if (toggle_ff != hdr0_ff[HDR_TOGGLE_BIT]) begin
                        toggle_in  = hdr0_ff[HDR_TOGGLE_BIT];
                        pending_in = 1'b1;
                     end
                  end
               end
            end
            PH_DATA: begin
               if (br_ff + HDR_LEN < breq_ff) begin
                  wr_en  = 1'b1;
                  crc_in = crc_fed;
               end else begin
                  trailer_in = trailer_new;
               end
               br_in = br_inc;
               if (br_inc >= breq_ff) begin
                  // group done: classify and hand off
                  phase_in   = PH_WAIT;
                  br_in      = 5'd0;
                  breq_in    = GROUP_OVERHEAD;
                  trailer_in = '0;
                  crc_in     = CRC_INIT;
                  if (!crc_ok) begin
                     push_valid    = 1'b1;
                     push_job.kind = KIND_CRC_FAIL;
                  end else if (hdr0_ff[HDR_CMD_BIT]) begin
                     if (hdr0_ff[3:0] == CMD_CLEAR) begin
                        push_valid    = 1'b1;
                        push_job.kind = KIND_CLEAR;
                     end
                  end else begin
                     push_valid              = 1'b1;
                     push_job.kind           = KIND_LABEL;
                     push_job.first_segment  = hdr0_ff[HDR_FIRST_BIT];
                     push_job.last_segment   = hdr0_ff[HDR_LAST_BIT];
                     push_job.segment_number = hdr0_ff[HDR_FIRST_BIT] ? 3'd0 : hdr1_ff[6:4];
                     push_job.charset        = hdr0_ff[HDR_FIRST_BIT] ? hdr1_ff[7:4] : 4'd0;
                     push_job.new_label      = pending_ff;
                     push_job.count_m1       = hdr0_ff[SEG_AW-1:0];
                     push_job.bank           = wbank_ff;
                     busy_in[wbank_ff]       = 1'b1;
                     wbank_in                = wbank_ff + 1'b1;
                     pending_in              = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         br_ff      <= 5'd0;
         breq_ff    <= GROUP_OVERHEAD;
         trailer_ff <= '0;
         crc_ff     <= CRC_INIT;
         toggle_ff  <= 1'b0;
         pending_ff <= 1'b0;
         wbank_ff   <= '0;
         busy_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         br_ff      <= br_in;
         breq_ff    <= breq_in;
         trailer_ff <= trailer_in;
         crc_ff     <= crc_in;
         toggle_ff  <= toggle_in;
         pending_ff <= pending_in;
         wbank_ff   <= wbank_in;
         busy_ff    <= busy_in;
      end
      hdr0_ff <= hdr0_in;
      hdr1_ff <= hdr1_in;
   end

endmodule

>>> rtl/core/dldg_queue.sv
// Two-entry job queue between the parser front end and the result sequencer.
// Uses dldg_pkg.
module dldg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  dldg_pkg::job_type push_job,
   input  logic              pop,
   output dldg_pkg::job_type head,
   output logic              full,
   output logic              empty
);
   import dldg_pkg::*;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0] rptr_ff, rptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = count_ff == QUEUE_AW'(QUEUE_DEPTH - 1) + (QUEUE_AW + 1)'(1);
   assign empty   = count_ff == '0;
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/dldg_back.sv
// Back end: pops jobs, reads label bytes from the segment RAM and drives the
// registered result channel. Uses dldg_pkg.
module dldg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  dldg_pkg::job_type           head,
   input  logic                        q_empty,
   output logic                        pop,
   output logic                        rd_en,
   output logic [dldg_pkg::RAM_AW-1:0] rd_addr,
   input  logic [7:0]                  rd_data,
   output dldg_pkg::bank_free_type     bank_free,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output dldg_pkg::rsp_type           rsp_data
);
   import dldg_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0]        state_ff, state_in;
   job_type           job_ff, job_in;
   logic [SEG_AW-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   assign rd_addr   = {job_ff.bank, idx_ff};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      bank_free    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               job_in = head;
               idx_in = '0;
               if (head.kind == KIND_LABEL) begin
                  state_in = ST_READ;
               end else begin
                  rsp_in             = '0;
                  rsp_in.kind        = head.kind;
                  rsp_in.last_of_run = 1'b1;
                  rsp_valid_in       = 1'b1;
                  state_in           = ST_SEND;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_in.kind           = KIND_LABEL;
            rsp_in.segment_number = job_ff.segment_number;
            rsp_in.charset        = job_ff.charset;
            rsp_in.first_segment  = job_ff.first_segment;
            rsp_in.last_segment   = job_ff.last_segment;
            rsp_in.new_label      = job_ff.new_label;
            rsp_in.byte_offset    = idx_ff;
            rsp_in.label_byte     = rd_data;
            rsp_in.last_of_run    = idx_ff == job_ff.count_m1;
            rsp_valid_in          = 1'b1;
            state_in              = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (job_ff.kind == KIND_LABEL && idx_ff != job_ff.count_m1) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
                  if (job_ff.kind == KIND_LABEL) begin
                     // last byte gone: hand the bank back to the front end
                     bank_free.valid = 1'b1;
                     bank_free.bank  = job_ff.bank;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

endmodule

>>> rtl/core/dab_dynamic_label_group_parser_unit.sv
// Dynamic label data group parser: one X-PAD byte per cycle enters while a free segment bank
// and a queue slot exist. A group's last byte queues its job; the sequencer registers a command or
// CRC failure result straight from the queue head, while each label byte is paced by the
// sequencer's read, load and send steps on the registered RAM port, and by rsp_stall.
// Two segment banks and a two-job queue let the next group arrive while results drain.
// Reset is synchronous and active high; no memory clearing pass is needed.
module dab_dynamic_label_group_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dldg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dldg_pkg::rsp_type rsp_data
);
   import dldg_pkg::*;

   job_type             push_job;
   logic                push_valid;
   job_type             head;
   logic                q_full;
   logic                q_empty;
   logic                pop;
   bank_free_type       bank_free;
   logic                wr_en;
   logic [RAM_AW-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic                rd_en;
   logic [RAM_AW-1:0]   rd_addr;
   logic [7:0]          rd_data;

   dldg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_job   (push_job),
      .q_full     (q_full),
      .bank_free  (bank_free),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   dldg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   dldg_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_seg_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dldg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .bank_free (bank_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("job popped from an empty queue");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_LABEL |-> rsp_data.last_of_run)
      else $error("command or CRC status result not marked last of run");

   a_label_push_after_write: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_job.kind == KIND_LABEL |=> !(wr_en && wr_addr[RAM_AW-1] ==
         push_job.bank && $past(push_valid)) || $past(push_job.bank) != push_job.bank)
      else $error("segment bank written right after it was handed off");
`endif

endmodule

>>> bench/tb_dab_dynamic_label_group_parser_unit.sv
// Testbench for the dynamic label group parser: random and directed X-PAD groups in,
// results checked against a behavioral predictor of the parser held in a small scoreboard.
// Depends on dldg_pkg and dab_dynamic_label_group_parser_unit.
`timescale 1ns / 1ps

module tb_dab_dynamic_label_group_parser_unit;
   import dldg_pkg::*;

   class label_scoreboard;
      typedef enum logic [1:0] {SEEK_START, IN_HEADER, IN_BODY} stage_type;
      localparam int CRC_BYTES = 2;

      stage_type   stage;
      int unsigned bytes_in;
      int unsigned group_len;
      logic [7:0]  hdr [2];
      logic [7:0]  seg_bytes [16];
      logic [15:0] trailer;
      logic [15:0] crc;
      logic        toggle_seen;
      logic        restart_pending;
      rsp_type     expected_results [$];
      int          errors;
      int          checked;
      int          kind_seen [4];

      function new();
         stage = SEEK_START;
         toggle_seen = 1'b0;
         restart_pending = 1'b0;
         errors = 0;
         checked = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
         restart_group();
      endfunction

      // serial CCITT update, one message bit at a time
      static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
         end
         return c;
      endfunction

      function void restart_group();
         bytes_in = 0;
         group_len = GROUP_OVERHEAD;
         trailer = '0;
         crc = CRC_INIT;
      endfunction

      function void push_status(logic [1:0] kind);
         rsp_type r;
         r = '0;
         r.kind = kind;
         r.last_of_run = 1'b1;
         expected_results.push_back(r);
      endfunction

      // advance the parser by one accepted byte; returns 1 if the byte belongs to a group
      function bit note_byte(req_type item);
         rsp_type     r;
         logic [7:0]  h0;
         logic [3:0]  f2;
         logic        first;
         int unsigned cnt;
         if (item.group_start) begin
            restart_group();
            stage = IN_HEADER;
         end else if (stage == SEEK_START) begin
            return 1'b0;
         end

         if (stage == IN_HEADER) begin
            hdr[bytes_in % 2] = item.data_byte;
            crc = crc_step(crc, item.data_byte);
            bytes_in++;
            if (bytes_in >= HDR_LEN) begin
               h0 = hdr[0];
               if (h0[HDR_CMD_BIT]) begin
                  group_len = GROUP_OVERHEAD;
               end else begin
                  group_len = GROUP_OVERHEAD + h0[3:0] + 1;
                  // the toggle is tracked even if this group never completes
                  if (h0[HDR_TOGGLE_BIT] != toggle_seen) begin
                     toggle_seen = h0[HDR_TOGGLE_BIT];
                     restart_pending = 1'b1;
                  end
               end
               stage = IN_BODY;
            end
            return 1'b1;
         end

         if (bytes_in + CRC_BYTES < group_len) begin
            seg_bytes[(bytes_in - HDR_LEN) % 16] = item.data_byte;
            crc = crc_step(crc, item.data_byte);
         end else begin
            trailer = {trailer[7:0], item.data_byte};
         end
         bytes_in++;
         if (bytes_in < group_len) return 1'b1;

         stage = SEEK_START;
         h0 = hdr[0];
         if (~crc != trailer) begin
            push_status(KIND_CRC_FAIL);
         end else if (h0[HDR_CMD_BIT]) begin
            // DL-plus and reserved commands leave no trace
            if (h0[3:0] == CMD_CLEAR) push_status(KIND_CLEAR);
         end else begin
            f2 = hdr[1][7:4];
            first = h0[HDR_FIRST_BIT];
            cnt = h0[3:0] + 1;
            for (int i = 0; i < cnt; i++) begin
               r = '0;
               r.kind = KIND_LABEL;
               r.segment_number = first ? 3'd0 : f2[2:0];
               r.charset = first ? f2 : 4'd0;
               r.first_segment = first;
               r.last_segment = h0[HDR_LAST_BIT];
               r.new_label = restart_pending;
               r.byte_offset = i[3:0];
               r.label_byte = seg_bytes[i];
               r.last_of_run = (i == cnt - 1);
               expected_results.push_back(r);
            end
            restart_pending = 1'b0;
         end
         restart_group();
         return 1'b1;
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      task compare_field(string name, int unsigned seen, int unsigned want);
         if (seen != want)
            report($sformatf("result %0d field %s: got %0d, expected %0d",
                             checked, name, seen, want));
      endtask

      task check_result(rsp_type seen);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("result with nothing expected: %h", seen));
            return;
         end
         want = expected_results.pop_front();
         checked++;
         kind_seen[want.kind]++;
         compare_field("kind", seen.kind, want.kind);
         compare_field("segment_number", seen.segment_number, want.segment_number);
         compare_field("charset", seen.charset, want.charset);
         compare_field("first_segment", seen.first_segment, want.first_segment);
         compare_field("last_segment", seen.last_segment, want.last_segment);
         compare_field("new_label", seen.new_label, want.new_label);
         compare_field("byte_offset", seen.byte_offset, want.byte_offset);
         compare_field("label_byte", seen.label_byte, want.label_byte);
         compare_field("last_of_run", seen.last_of_run, want.last_of_run);
      endtask
   endclass

   localparam int HOLD_CYCLES  = 400;
   localparam int ITEMS_PER_MIX = 72;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   label_scoreboard sb = new();

   int   send_idle_pct = 32;
   int   recv_idle_pct = 86;
   int   idle_mode = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   int   taken = 0;
   logic cur_toggle = 1'b1;

   dab_dynamic_label_group_parser_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   // result side: check taken beats, then pick the stall for the next edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (idle_mode == 2 && !hold_done) begin
            // long hold-off so the block backs up into its input
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic st);
      req_type item;
      item.data_byte = b;
      item.group_start = st;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      // hold the beat until the block takes it
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sb.note_byte(item)) taken++;
   endtask

   // keep: 0 sends the whole group, -1 a random prefix, otherwise that many bytes
   task automatic send_group(input logic [7:0] h0, input logic [7:0] h1,
                             input bit corrupt, input int keep);
      logic [7:0]  body [$];
      logic [15:0] c;
      int          n;
      int          k;
      body = {h0, h1};
      if (!h0[HDR_CMD_BIT]) repeat (h0[3:0] + 1) body.push_back(8'($urandom));
      c = CRC_INIT;
      foreach (body[i]) c = sb.crc_step(c, body[i]);
      c = ~c;
      body.push_back(c[15:8]);
      body.push_back(c[7:0]);
      if (corrupt) begin
         k = $urandom_range(HDR_LEN, body.size() - 1);
         body[k] = body[k] ^ (8'd1 << $urandom_range(0, 7));
      end
      if (keep < 0) n = $urandom_range(1, body.size() - 1);
      else if (keep == 0) n = body.size();
      else n = keep;
      for (int i = 0; i < n; i++) send_byte(body[i], i == 0);
   endtask

   task automatic send_random_group();
      int         pick;
      int         len;
      logic [7:0] rnd;
      logic [7:0] h0;
      logic [3:0] cmd;
      pick = $urandom_range(99);
      if (pick >= 90) begin
         // loose bytes, some of them opening groups that never finish
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
         return;
      end
      rnd = 8'($urandom);
      if ($urandom_range(99) < 70) begin
         if ($urandom_range(99) < 25) cur_toggle = ~cur_toggle;
         len = ($urandom_range(99) < 80) ? $urandom_range(0, 5) : $urandom_range(6, 15);
         h0 = {cur_toggle, rnd[1:0], 1'b0, len[3:0]};
      end else begin
         cmd = ($urandom_range(99) < 50) ? CMD_CLEAR : rnd[7:4];
         h0 = {rnd[2:0], 1'b1, cmd};
      end
      send_group(h0, 8'($urandom), pick >= 70 && pick < 80, (pick >= 80) ? -1 : 0);
   endtask

   initial begin
      int target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'hFF, 1'b0);              // outside any group: dropped
      send_group(8'h90, 8'h00, 1'b0, 0);   // clear display
      send_group(8'hC0, 8'hF0, 1'b0, 0);   // first segment, charset 15, toggle flips
      send_group(8'h12, 8'h3C, 1'b0, 0);   // DL-plus command: silent
      send_group(8'h1F, 8'hFF, 1'b1, 0);   // reserved command with broken CRC
      send_group(8'h4F, 8'h5A, 1'b0, 2);   // header only, then abandoned
      send_group(8'hA0, 8'h70, 1'b0, 0);   // last segment number 7, new label

      for (int m = 0; m < 3; m++) begin
         case (m)
            0: begin send_idle_pct = 32; recv_idle_pct = 86; end
            1: begin send_idle_pct = 86; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         idle_mode = m;
         target = taken + ITEMS_PER_MIX;
         while (taken < target) send_random_group();
      end
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Run covered %0d group bytes under three idle mixes and a %0d-cycle hold-off.",
               taken, HOLD_CYCLES);
      $display("Checked %0d results: %0d label bytes, %0d clears, %0d CRC failures.",
               sb.checked, sb.kind_seen[KIND_LABEL], sb.kind_seen[KIND_CLEAR],
               sb.kind_seen[KIND_CRC_FAIL]);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> files.f
rtl/core/dldg_pkg.sv
rtl/core/dldg_ram.sv
rtl/core/dldg_front.sv
rtl/core/dldg_queue.sv
rtl/core/dldg_back.sv
rtl/core/dab_dynamic_label_group_parser_unit.sv
bench/tb_dab_dynamic_label_group_parser_unit.sv
